@@ sv/tqm_pkg.sv @@
// tqm_pkg: shared types, codes and default sizes for the team queue manager.
// No dependencies; used by tqm_member_store and team_queue_manager.

package tqm_pkg;

	// default sizes, handed to the module parameters
	localparam int TEAMS_DEF       = 64;
	localparam int ELEMENT_IDS_DEF = 1024;
	localparam int SLOTS_DEF       = 256;

	// fixed field widths of an item
	localparam int KIND_W   = 2;
	localparam int ELEM_W   = 10;
	localparam int TEAM_W   = 6;
	localparam int STATUS_W = 2;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam kind_t KIND_ASSIGN  = 2'd0;
	localparam kind_t KIND_ENQUEUE = 2'd1;
	localparam kind_t KIND_DEQUEUE = 2'd2;
	localparam kind_t KIND_CLEAR   = 2'd3;

	// result codes
	localparam status_t STATUS_DONE      = 2'd0;
	localparam status_t STATUS_EMPTY     = 2'd1;
	localparam status_t STATUS_FULL      = 2'd2;
	localparam status_t STATUS_DELIVERED = 2'd3;

endpackage

@@ sv/tqm_member_store.sv @@
// tqm_member_store: element-to-team membership table, one port, registered read.
// Sweeps the table to team 0 after reset. Depends on tqm_pkg.

module tqm_member_store #(
	parameter int TEAMS       = tqm_pkg::TEAMS_DEF,
	parameter int ELEMENT_IDS = tqm_pkg::ELEMENT_IDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic                           wr_en,
	input  logic [$clog2(ELEMENT_IDS)-1:0] addr,
	input  logic [$clog2(TEAMS)-1:0]       wr_data,
	output logic [$clog2(TEAMS)-1:0]       rd_data,
	output logic                           init_busy
);

	localparam int EW = $clog2(ELEMENT_IDS);
	localparam int TW = $clog2(TEAMS);

	logic [TW-1:0] mem [ELEMENT_IDS];
	logic [TW-1:0] rd_data_q;
	logic [EW-1:0] init_cnt_q;
	logic          init_busy_q;

	// clearing pass: one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q  <= '0;
			init_busy_q <= 1'b1;
		end else if (init_busy_q) begin
			if (init_cnt_q == EW'(ELEMENT_IDS - 1)) begin
				init_busy_q <= 1'b0;
			end
			init_cnt_q <= init_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (init_busy_q) begin
			mem[init_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data   = rd_data_q;
	assign init_busy = init_busy_q;

endmodule

@@ sv/team_queue_manager.sv @@
// Timing: one item at a time. Assign, clear, dequeue on an empty pool and enqueue on a full
// pool finish in the state after accept; enqueue reads membership, then team head/tail;
// dequeue reads the order, the team head/tail, then the slot. The result lands in the output
// register as the last step ends, or is parked until that register is free; the next item can
// be taken in the cycle after. Reset: queues empty, all ids in team 0. The membership table is
// swept to zero after reset, with cmd_stall high.
//
// team_queue_manager: top level. Depends on tqm_pkg and tqm_member_store.

module team_queue_manager #(
	parameter int TEAMS       = tqm_pkg::TEAMS_DEF,
	parameter int ELEMENT_IDS = tqm_pkg::ELEMENT_IDS_DEF,
	parameter int SLOTS       = tqm_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  tqm_pkg::kind_t              kind,
	input  logic [tqm_pkg::ELEM_W-1:0]  element,
	input  logic [tqm_pkg::TEAM_W-1:0]  team,
	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [tqm_pkg::ELEM_W-1:0]  element_out,
	output tqm_pkg::status_t            status
);

	localparam int EW     = $clog2(ELEMENT_IDS);
	localparam int TW     = $clog2(TEAMS);
	localparam int SW     = $clog2(SLOTS);
	localparam int UW     = $clog2(SLOTS + 1);
	localparam int EXT_EW = EW + tqm_pkg::ELEM_W;
	localparam int EXT_TW = TW + tqm_pkg::TEAM_W;

	// sequencer states
	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ENQ1 = 3'd2;
	localparam logic [2:0] ST_ENQ2 = 3'd3;
	localparam logic [2:0] ST_DEQ1 = 3'd4;
	localparam logic [2:0] ST_DEQ2 = 3'd5;
	localparam logic [2:0] ST_DEQ3 = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0] state_q, state_d;
	logic       acc;

	// membership table
	logic [EXT_EW-1:0] elem_ext;
	logic [EXT_TW-1:0] team_ext;
	logic              elem_ok_in, team_ok_in;
	logic              mbr_we, init_busy;
	logic [TW-1:0]     mbr_rd;

	// item held while it is worked on
	logic [tqm_pkg::ELEM_W-1:0] element_q;
	logic                       elem_ok_q;
	logic [TW-1:0]              team_q, enq_team;
	logic [SW-1:0]              slot_q;

	// free list: a stack of returned slots on top of a never-used watermark
	logic [SW-1:0] free_head_q, fresh_head;
	logic [UW-1:0] fresh_q, used_q;
	logic          from_fresh, pool_full, pool_empty;

	// team order ring and active flags
	logic [TEAMS-1:0] active_q;
	logic             team_act;
	logic [TW-1:0]    ord_rd_q, ord_wr_q, ord_rd_next, ord_wr_next;

	// memories
	logic [tqm_pkg::ELEM_W-1:0] val_mem [SLOTS];
	logic [tqm_pkg::ELEM_W-1:0] val_rd;
	logic                       val_we, val_re;
	logic [SW-1:0]              link_mem [SLOTS];
	logic [SW-1:0]              link_rd, link_raddr, link_waddr, link_wdata;
	logic                       link_re, link_we;
	logic [2*SW-1:0]            team_mem [TEAMS];
	logic [2*SW-1:0]            team_rd, team_wdata;
	logic [TW-1:0]              team_raddr;
	logic                       team_re, team_we;
	logic [SW-1:0]              head_rd, tail_rd;
	logic                       last_in_team;
	logic [TW-1:0]              order_mem [TEAMS];
	logic [TW-1:0]              order_rd;
	logic                       order_we;

	// result path
	logic                       fin, out_free, load_out;
	logic [tqm_pkg::ELEM_W-1:0] fin_elem, load_elem, pend_elem_q, elem_out_q;
	tqm_pkg::status_t           fin_status, load_status, pend_status_q, status_q;
	logic                       res_valid_q;

	assign cmd_stall = (state_q != ST_IDLE);
	assign acc       = cmd_valid && !cmd_stall;

	// ---------------------------------------------------------------
	// Membership: read at accept for enqueue, written at accept for assign.
	// Ids or teams beyond the table are ignored on assign.
	// ---------------------------------------------------------------
	assign elem_ext   = EXT_EW'(element);
	assign team_ext   = EXT_TW'(team);
	assign elem_ok_in = 32'(element) < ELEMENT_IDS;
	assign team_ok_in = 32'(team) < TEAMS;
	assign mbr_we     = acc && (kind == tqm_pkg::KIND_ASSIGN) && elem_ok_in && team_ok_in;

	tqm_member_store #(
		.TEAMS       (TEAMS),
		.ELEMENT_IDS (ELEMENT_IDS)
	) u_member (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.wr_en     (mbr_we),
		.addr      (elem_ext[EW-1:0]),
		.wr_data   (team_ext[TW-1:0]),
		.rd_data   (mbr_rd),
		.init_busy (init_busy)
	);

	// an id outside the table enqueues as team 0
	assign enq_team = elem_ok_q ? mbr_rd : '0;

	// ---------------------------------------------------------------
	// Pool bookkeeping
	// ---------------------------------------------------------------
	assign pool_full  = (used_q == UW'(SLOTS));
	assign pool_empty = (used_q == '0);
	// the head is the watermark only when no returned slot is stacked
	assign from_fresh = (UW'(free_head_q) == fresh_q);
	assign fresh_head = (fresh_q == UW'(SLOTS - 1)) ? '0 : SW'(fresh_q + 1'b1);

	assign ord_rd_next = (ord_rd_q == TW'(TEAMS - 1)) ? '0 : ord_rd_q + 1'b1;
	assign ord_wr_next = (ord_wr_q == TW'(TEAMS - 1)) ? '0 : ord_wr_q + 1'b1;

	assign team_act              = active_q[team_q];
	assign {head_rd, tail_rd}    = team_rd;
	assign last_in_team          = (head_rd == tail_rd);

	// ---------------------------------------------------------------
	// Memory ports. Every access of one item is in a different cycle
	// from any write of the same item, and items never overlap, so no
	// forwarding is needed.
	// ---------------------------------------------------------------
	assign val_we = (state_q == ST_ENQ1) && !pool_full;
	assign val_re = (state_q == ST_DEQ2);

	// link: next free slot at accept, next team member in DEQ2
	assign link_re    = acc || (state_q == ST_DEQ2);
	assign link_raddr = (state_q == ST_DEQ2) ? head_rd : free_head_q;
	// ENQ2 chains the new slot behind the team tail; DEQ3 pushes the freed slot
	assign link_we    = ((state_q == ST_ENQ2) && team_act) || (state_q == ST_DEQ3);
	assign link_waddr = (state_q == ST_DEQ3) ? head_rd : tail_rd;
	assign link_wdata = (state_q == ST_DEQ3) ? free_head_q : slot_q;

	assign team_re    = ((state_q == ST_ENQ1) && !pool_full) ||
	                    ((state_q == ST_DEQ1) && !pool_empty);
	assign team_raddr = (state_q == ST_ENQ1) ? enq_team : order_rd;
	assign team_we    = (state_q == ST_ENQ2) || ((state_q == ST_DEQ3) && !last_in_team);

	always_comb begin
		if (state_q == ST_DEQ3) begin
			team_wdata = {link_rd, tail_rd};
		end else if (team_act) begin
			team_wdata = {head_rd, slot_q};
		end else begin
			team_wdata = {slot_q, slot_q};
		end
	end

	// a team with nothing queued joins the back of the order
	assign order_we = (state_q == ST_ENQ2) && !team_act;

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[free_head_q] <= element_q;
		end
		if (val_re) begin
			val_rd <= val_mem[head_rd];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (link_re) begin
			link_rd <= link_mem[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (team_we) begin
			team_mem[team_q] <= team_wdata;
		end
		if (team_re) begin
			team_rd <= team_mem[team_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[ord_wr_q] <= team_q;
		end
		if (acc) begin
			order_rd <= order_mem[ord_rd_q];
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_elem   = '0;
		fin_status = tqm_pkg::STATUS_DONE;
		case (state_q)
			ST_INIT: begin
				if (!init_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (kind)
						tqm_pkg::KIND_ENQUEUE: state_d = ST_ENQ1;
						tqm_pkg::KIND_DEQUEUE: state_d = ST_DEQ1;
						default:               state_d = ST_DONE;
					endcase
				end
			end
			ST_ENQ1: begin
				if (pool_full) begin
					fin        = 1'b1;
					fin_status = tqm_pkg::STATUS_FULL;
				end else begin
					state_d = ST_ENQ2;
				end
			end
			ST_ENQ2: begin
				fin = 1'b1;
			end
			ST_DEQ1: begin
				if (pool_empty) begin
					fin        = 1'b1;
					fin_status = tqm_pkg::STATUS_EMPTY;
				end else begin
					state_d = ST_DEQ2;
				end
			end
			ST_DEQ2: begin
				state_d = ST_DEQ3;
			end
			ST_DEQ3: begin
				fin        = 1'b1;
				fin_elem   = val_rd;
				fin_status = tqm_pkg::STATUS_DELIVERED;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// park the result when the output register is still occupied
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_DONE;
		end
	end

	assign load_out    = out_free && (fin || (state_q == ST_DONE));
	assign load_elem   = fin ? fin_elem : pend_elem_q;
	assign load_status = fin ? fin_status : pend_status_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			free_head_q <= '0;
			fresh_q     <= '0;
			used_q      <= '0;
			active_q    <= '0;
			ord_rd_q    <= '0;
			ord_wr_q    <= '0;
		end else begin
			state_q <= state_d;
			// clear keeps memberships, empties everything else
			if (acc && (kind == tqm_pkg::KIND_CLEAR)) begin
				free_head_q <= '0;
				fresh_q     <= '0;
				used_q      <= '0;
				active_q    <= '0;
				ord_rd_q    <= '0;
				ord_wr_q    <= '0;
			end
			if ((state_q == ST_ENQ1) && !pool_full) begin
				free_head_q <= from_fresh ? fresh_head : link_rd;
				if (from_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
				used_q <= used_q + 1'b1;
			end
			if ((state_q == ST_ENQ2) && !team_act) begin
				active_q[team_q] <= 1'b1;
				ord_wr_q         <= ord_wr_next;
			end
			if (state_q == ST_DEQ3) begin
				// team leaves the order once its last element goes
				if (last_in_team) begin
					active_q[team_q] <= 1'b0;
					ord_rd_q         <= ord_rd_next;
				end
				free_head_q <= head_rd;
				used_q      <= used_q - 1'b1;
			end
		end
	end

	// item payload and parked result
	always_ff @(posedge clk) begin
		if (acc) begin
			element_q     <= element;
			elem_ok_q     <= elem_ok_in;
			pend_elem_q   <= '0;
			pend_status_q <= tqm_pkg::STATUS_DONE;
		end
		if ((state_q == ST_ENQ1) && !pool_full) begin
			slot_q <= free_head_q;
			team_q <= enq_team;
		end
		if ((state_q == ST_DEQ1) && !pool_empty) begin
			team_q <= order_rd;
		end
		if (fin) begin
			pend_elem_q   <= fin_elem;
			pend_status_q <= fin_status;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			elem_out_q <= load_elem;
			status_q   <= load_status;
		end
	end

	assign res_valid   = res_valid_q;
	assign element_out = elem_out_q;
	assign status      = status_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// stacked free slots = fresh_q - used_q, never negative
	a_pool_count: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q <= fresh_q) && (fresh_q <= UW'(SLOTS)))
		else $error("pool counters inconsistent");

	a_active_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((used_q == '0) == (active_q == '0)))
		else $error("active teams disagree with slot count");

	a_init_stall: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> cmd_stall)
		else $error("command taken during membership sweep");

	a_deq_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEQ3) |=> (used_q == $past(used_q) - 1'b1))
		else $error("dequeue did not release a slot");

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for team_queue_manager, driving commands and checking results
// against a built-in team-queue predictor. Depends on tqm_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
	import tqm_pkg::*;

	localparam int SLOT_W       = $clog2(SLOTS_DEF);
	localparam int RING_W       = $clog2(TEAMS_DEF);
	localparam int DRAIN_CYCLES = 8;       // longest item is a dequeue
	localparam int CYCLE_LIMIT  = 200000;  // sweep + ~1800 items under heavy idling, many times over

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [TEAM_W-1:0] team_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [RING_W-1:0] ring_t;

	typedef struct packed {
		elem_t   elem;
		status_t st;
	} outcome_t;

	logic    clk;
	logic    arst_n;
	logic    cmd_valid;
	logic    cmd_stall;
	kind_t   kind;
	elem_t   element;
	team_t   team;
	logic    res_valid;
	logic    res_stall;
	elem_t   element_out;
	status_t status;

	team_queue_manager dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.kind        (kind),
		.element     (element),
		.team        (team),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.element_out (element_out),
		.status      (status)
	);

	// ---------------------------------------------------------------
	// Predictor state: membership table, slot pool with per-team
	// chains, a free list and a ring of teams in service order.
	// ---------------------------------------------------------------
	team_t       team_of      [ELEMENT_IDS_DEF];
	elem_t       pool_elem    [SLOTS_DEF];
	slot_t       pool_next    [SLOTS_DEF];
	slot_t       free_first;
	int unsigned pool_used;
	slot_t       team_first   [TEAMS_DEF];
	slot_t       team_last    [TEAMS_DEF];
	bit          team_busy    [TEAMS_DEF];
	team_t       service_ring [TEAMS_DEF];
	ring_t       ring_rd;
	ring_t       ring_wr;

	outcome_t    awaited_q[$];   // results owed by the block, oldest first
	int          error_count;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_request;   // cycles of hold-off for the receiver to take up

	// Clear keeps memberships; only the queues, free list and ring go.
	function automatic void empty_all_queues();
		for (int i = 0; i < SLOTS_DEF; i++)
			pool_next[i] = slot_t'(i + 1);
		for (int i = 0; i < TEAMS_DEF; i++)
			team_busy[i] = 1'b0;
		free_first = '0;
		pool_used  = 0;
		ring_rd    = '0;
		ring_wr    = '0;
	endfunction

	function automatic void forget_memberships();
		for (int i = 0; i < ELEMENT_IDS_DEF; i++)
			team_of[i] = '0;
	endfunction

	// Works out the one result of an item and moves the predictor on.
	function automatic outcome_t serve_item(kind_t k, elem_t e, team_t t);
		outcome_t r;
		team_t    tm;
		slot_t    s;
		r.elem = '0;
		r.st   = STATUS_DONE;
		case (k)
			KIND_ASSIGN: begin
				team_of[e] = t;
			end
			KIND_ENQUEUE: begin
				tm = team_of[e];
				if (pool_used >= SLOTS_DEF) begin
					r.st = STATUS_FULL;
				end else begin
					s            = free_first;
					free_first   = pool_next[s];
					pool_elem[s] = e;
					pool_next[s] = '0;
					if (team_busy[tm]) begin
						// join behind the last queued team-mate
						pool_next[team_last[tm]] = s;
						team_last[tm]            = s;
					end else begin
						// team goes to the back of the service order
						team_first[tm]        = s;
						team_last[tm]         = s;
						team_busy[tm]         = 1'b1;
						service_ring[ring_wr] = tm;
						ring_wr               = ring_wr + 1'b1;
					end
					pool_used++;
				end
			end
			KIND_DEQUEUE: begin
				if (pool_used == 0) begin
					r.st = STATUS_EMPTY;
				end else begin
					tm     = service_ring[ring_rd];
					s      = team_first[tm];
					r.elem = pool_elem[s];
					r.st   = STATUS_DELIVERED;
					if (s == team_last[tm]) begin
						team_busy[tm] = 1'b0;
						ring_rd       = ring_rd + 1'b1;
					end else begin
						team_first[tm] = pool_next[s];
					end
					pool_next[s] = free_first;
					free_first   = s;
					pool_used--;
				end
			end
			default: begin
				empty_all_queues();
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Clock, cycle count and watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result side: random stall, or a long hold-off when a test asks.
	// ---------------------------------------------------------------
	initial begin : receiver
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				held         = hold_request;
				hold_request = 0;
			end
			if (held > 0) begin
				held--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic report_mismatch(string msg);
		error_count++;
		$display("mismatch, cycle %0d: %s", cycle_count, msg);
	endtask

	// Every accepted result is held against the oldest owed one.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (awaited_q.size() == 0) begin
				report_mismatch($sformatf("result with none owed: element_out %0d status %0d",
					element_out, status));
			end else begin
				want = awaited_q.pop_front();
				if (element_out !== want.elem)
					report_mismatch($sformatf("element_out %0d, wanted %0d",
						element_out, want.elem));
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
			end
		end
	end

	// ---------------------------------------------------------------
	// Command side
	// ---------------------------------------------------------------
	// Offers one item, idling first at the current rate; the payload
	// holds until the block takes it. Valid is left high for the next.
	task automatic send_item(kind_t k, elem_t e, team_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		kind      <= k;
		element   <= e;
		team      <= t;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		awaited_q.insert(awaited_q.size(), serve_item(k, e, t));
	endtask

	// Sender stops until every owed result is in, then lets the block settle.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly a handful of recurring ids at both ends of the range, so
	// team-mates meet in the queue; the rest anywhere.
	function automatic elem_t pick_element();
		if ($urandom_range(99) < 70)
			return $urandom_range(1) ? elem_t'($urandom_range(15))
				: elem_t'(ELEMENT_IDS_DEF - 16 + $urandom_range(15));
		return elem_t'($urandom_range(ELEMENT_IDS_DEF - 1));
	endfunction

	function automatic team_t pick_team();
		if ($urandom_range(99) < 75)
			return team_t'($urandom_range(3));
		return team_t'($urandom_range(TEAMS_DEF - 1));
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Hand-picked items: empty dequeue, reassign of a queued id, team
	// joining and leaving the order, field extremes, clear keeping teams.
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(KIND_DEQUEUE, 10'h3FF, 6'h3F);   // nothing queued
		send_item(KIND_ENQUEUE, 10'h000, 6'h3F);   // unassigned, so team 0
		send_item(KIND_ASSIGN,  10'h3FF, 6'h3F);
		send_item(KIND_ASSIGN,  10'h000, 6'h3F);   // queued copy of 0 stays in team 0
		send_item(KIND_ENQUEUE, 10'h3FF, 6'h00);   // team 63 joins behind team 0
		send_item(KIND_ENQUEUE, 10'h000, 6'h00);   // now behind 1023
		send_item(KIND_ENQUEUE, 10'h005, 6'h2A);   // team 0, behind the first 0
		send_item(KIND_ASSIGN,  10'h2AA, 6'h2A);
		send_item(KIND_ASSIGN,  10'h155, 6'h15);
		send_item(KIND_ENQUEUE, 10'h155, 6'h00);
		send_item(KIND_ENQUEUE, 10'h2AA, 6'h00);
		send_item(KIND_DEQUEUE, 10'h155, 6'h15);
		send_item(KIND_DEQUEUE, 10'h000, 6'h00);   // team 0 empties, leaves the order
		send_item(KIND_ENQUEUE, 10'h007, 6'h00);   // team 0 rejoins at the back
		repeat (5) send_item(KIND_DEQUEUE, 10'h2AA, 6'h2A);
		send_item(KIND_DEQUEUE, 10'h000, 6'h00);   // empty again
		send_item(KIND_ENQUEUE, 10'h3FF, 6'h00);
		send_item(KIND_CLEAR,   10'h3FF, 6'h3F);
		send_item(KIND_DEQUEUE, 10'h000, 6'h00);   // clear left nothing behind
		send_item(KIND_ENQUEUE, 10'h000, 6'h00);   // still team 63 after the clear
		send_item(KIND_DEQUEUE, 10'h000, 6'h00);
		drain_results();
	endtask

	// Fills every slot, overflows, frees one, overflows again, then empties.
	task automatic test_pool_full();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (SLOTS_DEF + 2)
			send_item(KIND_ENQUEUE, elem_t'($urandom_range(ELEMENT_IDS_DEF - 1)), pick_team());
		send_item(KIND_DEQUEUE, pick_element(), pick_team());
		send_item(KIND_ENQUEUE, pick_element(), pick_team());
		send_item(KIND_ENQUEUE, pick_element(), pick_team());
		repeat (SLOTS_DEF + 1)
			send_item(KIND_DEQUEUE, pick_element(), pick_team());
		drain_results();
	endtask

	// Random mix; enq_weight in percent tilts the pool towards full or empty.
	task automatic test_random(int count, int idle_pct, int stall_pct, int enq_weight);
		int    roll;
		kind_t k;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 2)
				k = KIND_CLEAR;
			else if (roll < 17)
				k = KIND_ASSIGN;
			else if (roll < 17 + enq_weight)
				k = KIND_ENQUEUE;
			else
				k = KIND_DEQUEUE;
			send_item(k, pick_element(), pick_team());
		end
		drain_results();
	endtask

	// Receiver holds off for a long stretch while items keep coming, so
	// the output register fills and the block stalls its command side.
	task automatic test_hold_off();
		hold_request = 250;
		test_random(40, 0, 0, 45);
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 0;
		forget_memberships();
		empty_all_queues();
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		kind      <= KIND_ASSIGN;
		element   <= '0;
		team      <= '0;
		res_stall <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// the membership sweep after reset shows up as cmd_stall; send_item waits it out

		test_directed();
		test_pool_full();
		test_random(250, 0, 0, 45);
		test_random(250, 71, 0, 50);
		test_random(250, 0, 71, 35);
		test_random(250, 20, 20, 42);
		test_hold_off();
		test_random(200, 20, 20, 60);

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
